[hdl/urav_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package urav_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM  = 2'd3;

  localparam logic [9:0]  TRIG_WIDTH_RST = 10'd20;
  localparam logic [15:0] SETTLE_GAP_RST = 16'd50000;
  localparam logic [3:0]  ROUNDS_RST     = 4'd5;
  localparam logic [7:0]  US_PER_CM_RST  = 8'd58;

  // Default sizing
  localparam int MAX_ROUNDS_DEF = 8;
  localparam int ECHO_COUNT_BITS_DEF = 16;

  localparam int TIMER_W = 16;
  localparam int DIST_W = 16;

  // Measurement phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TRIG   = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;

  // Per-item status from the phase controller
  typedef struct packed {
    logic trig;
    logic busy;
    logic finish;
  } step_t;

endpackage
`default_nettype wire

[hdl/urav_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module urav_ctrl #(
  parameter int MAX_ROUNDS = 8,
  parameter int ECHO_COUNT_BITS = 16,
  parameter int SUM_W = 20,
  parameter int RND_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tick_i,
  input  wire logic             start_i,
  input  wire logic             echo_i,
  input  wire logic [9:0]       trig_width_i,
  input  wire logic [15:0]      settle_gap_i,
  input  wire logic [3:0]       rounds_i,
  output urav_pkg::step_t       step_o,
  output logic [SUM_W-1:0]      sum_o,
  output logic [RND_W-1:0]      eff_rounds_o
);
  import urav_pkg::*;

  localparam int CW = (RND_W > 4) ? RND_W : 4;
  localparam logic [CW-1:0] MAX_R = CW'(MAX_ROUNDS);

  logic [2:0]                 phase_q, phase_d;
  logic [TIMER_W-1:0]         timer_q, timer_d;
  logic [TIMER_W-1:0]         timer_inc;
  logic [ECHO_COUNT_BITS-1:0] echo_q, echo_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [RND_W-1:0]           rnd_q, rnd_d;
  logic [CW-1:0]              rounds_ext;
  logic [RND_W-1:0]           eff_rounds;
  logic [9:0]                 tw_eff;
  logic                       finish;

  always_comb begin
    rounds_ext = CW'(rounds_i);
    if (rounds_ext == '0) begin
      eff_rounds = RND_W'(1);
    end else if (rounds_ext > MAX_R) begin
      eff_rounds = RND_W'(MAX_ROUNDS);
    end else begin
      eff_rounds = RND_W'(rounds_ext);
    end
  end

  assign tw_eff = (trig_width_i == '0) ? 10'd1 : trig_width_i;
  assign timer_inc = timer_q + TIMER_W'(1);

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    echo_d  = echo_q;
    sum_d   = sum_q;
    rnd_d   = rnd_q;
    finish  = 1'b0;
    if (tick_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            sum_d   = '0;
            rnd_d   = '0;
            echo_d  = '0;
            phase_d = PH_TRIG;
            timer_d = '0;
          end
        end
        PH_TRIG: begin
          timer_d = timer_inc;
          if (timer_inc >= TIMER_W'(tw_eff)) begin
            phase_d = PH_WAIT;
            timer_d = '0;
          end
        end
        PH_WAIT: begin
          if (echo_i) begin
            echo_d  = ECHO_COUNT_BITS'(1);
            phase_d = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (echo_i) begin
            if (echo_q != '1) echo_d = echo_q + ECHO_COUNT_BITS'(1);
          end else begin
            sum_d = sum_q + SUM_W'(echo_q);
            rnd_d = rnd_q + RND_W'(1);
            timer_d = '0;
            if (settle_gap_i == '0) begin
              finish  = (rnd_d >= eff_rounds);
              phase_d = finish ? PH_IDLE : PH_TRIG;
            end else begin
              phase_d = PH_SETTLE;
            end
          end
        end
        PH_SETTLE: begin
          timer_d = timer_inc;
          if (timer_inc >= settle_gap_i) begin
            finish  = (rnd_q >= eff_rounds);
            phase_d = finish ? PH_IDLE : PH_TRIG;
            timer_d = '0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      echo_q  <= '0;
      sum_q   <= '0;
      rnd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      echo_q  <= echo_d;
      sum_q   <= sum_d;
      rnd_q   <= rnd_d;
    end
  end

  assign step_o.trig   = (phase_d == PH_TRIG);
  assign step_o.busy   = (phase_d != PH_IDLE);
  assign step_o.finish = finish;
  assign sum_o         = sum_d;
  assign eff_rounds_o  = eff_rounds;

endmodule
`default_nettype wire

[hdl/urav_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module urav_div #(
  parameter int SUM_W = 20,
  parameter int RND_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [7:0]       us_per_cm_i,
  input  wire logic [RND_W-1:0] rounds_i,
  output logic                  done_o,
  output logic [SUM_W-1:0]      quot_o
);
  import urav_pkg::*;

  localparam int DIV_W = 8 + RND_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q;
  logic [SUM_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [7:0]       div_eff;

  assign div_eff = (us_per_cm_i == '0) ? 8'd1 : us_per_cm_i;
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(SUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= DIV_W'(div_eff) * DIV_W'(rounds_i);
    end else if (run_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

[hdl/ultrasonic_range_averager.sv]
// Ultrasonic trigger/echo ranging controller with averaging.
// Input channel (in_valid_i / in_stall_o): one item per microsecond tick,
// carrying start_request_i and the sampled echo_level_i. An item is taken
// when in_valid_i is high and in_stall_o is low.
// Output channel (out_valid_o / out_stall_i): exactly one item per input
// item: trigger_level_o, busy_res_o, reading_done_o and distance_cm_o,
// all showing the state after that tick.
// An ordinary tick's result is registered and shows in the cycle after it is
// taken, and the next tick can be taken in that same cycle unless the
// receiver stalls. The tick that closes a reading runs the restoring
// divider, one quotient bit per cycle, and the input stalls until its
// result shows.
// Config (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written only while idle,
// which the block does not enforce. Reset: registers return to defaults
// (20 us, 50000 us, 5 rounds, 58 us/cm), phase idle, stored distance 0.
// Receiver stall: the output item is held; the input stalls until the
// output register can take the next result.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_range_averager #(
  parameter int MAX_ROUNDS = urav_pkg::MAX_ROUNDS_DEF,
  parameter int ECHO_COUNT_BITS = urav_pkg::ECHO_COUNT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [urav_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [urav_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           start_request_i,
  input  wire logic                           echo_level_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                trigger_level_o,
  output logic                                busy_res_o,
  output logic                                reading_done_o,
  output logic [urav_pkg::DIST_W-1:0]         distance_cm_o
);
  import urav_pkg::*;

  localparam int RND_W = $clog2(MAX_ROUNDS + 1);
  localparam int SUM_W = ECHO_COUNT_BITS + RND_W;
  localparam int QW = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic [9:0]  trig_width_q;
  logic [15:0] settle_gap_q;
  logic [3:0]  rounds_q;
  logic [7:0]  us_per_cm_q;

  logic              state_q;
  logic              accept;
  step_t             step;
  logic [SUM_W-1:0]  sum;
  logic [RND_W-1:0]  eff_rounds;
  logic              div_done;
  logic [SUM_W-1:0]  quot;
  logic [QW-1:0]     quot_ext;
  logic [DIST_W-1:0] quot_sat;

  logic              out_valid_q;
  logic              trig_q;
  logic              busy_q;
  logic              done_q;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] last_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q <= TRIG_WIDTH_RST;
      settle_gap_q <= SETTLE_GAP_RST;
      rounds_q     <= ROUNDS_RST;
      us_per_cm_q  <= US_PER_CM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIG_WIDTH: trig_width_q <= cfg_data_i[9:0];
        REG_SETTLE_GAP: settle_gap_q <= cfg_data_i[15:0];
        REG_ROUNDS:     rounds_q     <= cfg_data_i[3:0];
        REG_US_PER_CM:  us_per_cm_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  urav_ctrl #(
    .MAX_ROUNDS      (MAX_ROUNDS),
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS),
    .SUM_W           (SUM_W),
    .RND_W           (RND_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (accept),
    .start_i      (start_request_i),
    .echo_i       (echo_level_i),
    .trig_width_i (trig_width_q),
    .settle_gap_i (settle_gap_q),
    .rounds_i     (rounds_q),
    .step_o       (step),
    .sum_o        (sum),
    .eff_rounds_o (eff_rounds)
  );

  urav_div #(
    .SUM_W (SUM_W),
    .RND_W (RND_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && step.finish),
    .dividend_i  (sum),
    .us_per_cm_i (us_per_cm_q),
    .rounds_i    (eff_rounds),
    .done_o      (div_done),
    .quot_o      (quot)
  );

  assign quot_ext = QW'(quot);
  assign quot_sat = (|quot_ext[QW-1:DIST_W]) ? '1 : quot_ext[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_dist_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && step.finish) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q     <= S_IDLE;
            last_dist_q <= quot_sat;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // a new item wins over the one being taken this cycle
      if ((accept && !step.finish) || (state_q == S_DIV && div_done)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      trig_q <= step.trig;
      busy_q <= step.busy;
      done_q <= step.finish;
      dist_q <= last_dist_q;
    end else if (state_q == S_DIV && div_done) begin
      dist_q <= quot_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = trig_q;
  assign busy_res_o      = busy_q;
  assign reading_done_o  = done_q;
  assign distance_cm_o   = dist_q;

endmodule
`default_nettype wire
